@@ src/gpqbp_pkg.sv @@
// Shared types and constants for the gray pixel quantizer and bit packer.
`default_nettype none

package gpqbp_pkg;

  localparam int PIX_W   = 8;
  localparam int BYTE_W  = 8;
  localparam int BPP_W   = 3;
  localparam int FILL_W  = 3;
  localparam int TOTAL_W = 4;
  localparam int ACC_W   = 16;
  localparam int SHAMT_W = 5;
  localparam int CNT_W   = 2;

  localparam logic [BPP_W-1:0] BPP_RESET = 3'd4;
  localparam logic [BPP_W-1:0] BPP_ZERO  = 3'd0;
  localparam logic [BPP_W-1:0] BPP_MIN   = 3'd1;

  // One packed output item
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } out_item_t;

  // Up to two output items produced by one pixel, in delivery order
  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    out_item_t        item0;
    out_item_t        item1;
  } out_group_t;

  // Full result of packing one pixel
  typedef struct packed {
    out_group_t         grp;
    logic [BYTE_W-1:0]  partial_nxt;
    logic [FILL_W-1:0]  fill_nxt;
  } pack_res_t;

endpackage

`default_nettype wire

@@ src/gpqbp_quant_pack.sv @@
// Quantize one pixel and merge its code into the partial byte.
`default_nettype none

module gpqbp_quant_pack
  import gpqbp_pkg::*;
(
  input  logic [PIX_W-1:0]  pixel,
  input  logic              last_pixel,
  input  logic [BPP_W-1:0]  bits_per_pixel,
  input  logic [BYTE_W-1:0] partial,
  input  logic [FILL_W-1:0] fill,
  output pack_res_t         res
);

  logic [BPP_W-1:0]   width;
  logic [TOTAL_W-1:0] code_shift;
  logic [PIX_W-1:0]   code;
  logic [TOTAL_W-1:0] total;
  logic [SHAMT_W-1:0] shamt;
  logic [ACC_W-1:0]   code_aligned;
  logic [ACC_W-1:0]   acc;
  logic               full;
  logic [BYTE_W-1:0]  part_mid;
  logic [FILL_W-1:0]  fill_mid;

  // Saturate a zero width to one bit, keep the top bits of the pixel
  assign width      = (bits_per_pixel == BPP_ZERO) ? BPP_MIN : bits_per_pixel;
  assign code_shift = TOTAL_W'(PIX_W) - {1'b0, width};
  assign code       = pixel >> code_shift;

  // Place the code right after the bits already gathered
  assign total        = {1'b0, fill} + {1'b0, width};
  assign shamt        = SHAMT_W'(ACC_W) - {1'b0, total};
  assign code_aligned = {{(ACC_W-PIX_W){1'b0}}, code} << shamt;
  assign acc          = {partial, {BYTE_W{1'b0}}} | code_aligned;
  assign full         = (total >= TOTAL_W'(BYTE_W));

  always_comb begin
    part_mid = full ? acc[BYTE_W-1:0] : acc[ACC_W-1:BYTE_W];
    fill_mid = full ? FILL_W'(total - TOTAL_W'(BYTE_W)) : FILL_W'(total);

    res             = '0;
    res.partial_nxt = part_mid;
    res.fill_nxt    = fill_mid;

    // Emit a completed byte first
    if (full) begin
      res.grp.cnt        = CNT_W'(1);
      res.grp.item0.data = acc[ACC_W-1:BYTE_W];
      res.grp.item0.last = 1'b0;
    end

    // On the last pixel flush any partial byte, or flag the full one
    if (last_pixel) begin
      if (fill_mid != '0) begin
        if (full) begin
          res.grp.cnt        = CNT_W'(2);
          res.grp.item1.data = part_mid;
          res.grp.item1.last = 1'b1;
        end else begin
          res.grp.cnt        = CNT_W'(1);
          res.grp.item0.data = part_mid;
          res.grp.item0.last = 1'b1;
        end
      end else if (full) begin
        res.grp.item0.last = 1'b1;
      end
      res.partial_nxt = '0;
      res.fill_nxt    = '0;
    end
  end

endmodule

`default_nettype wire

@@ src/gpqbp_out_queue.sv @@
// Two-entry output queue that takes up to two items per cycle when they fit and sends one when out_stall is low.
`default_nettype none

module gpqbp_out_queue
  import gpqbp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_valid,
  input  out_group_t push_grp,
  output logic       push_ready,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_item
);

  out_item_t        q0_r, q0_nxt;
  out_item_t        q1_r, q1_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             pop;
  logic [CNT_W-1:0] rem;
  logic [CNT_W-1:0] push_cnt;
  logic             push;

  assign out_valid = (cnt_r != '0);
  assign out_item  = q0_r;
  assign pop       = out_valid && !out_stall;
  assign rem       = cnt_r - CNT_W'(pop);

  // Accept a group only if it fits after this cycle's pop
  assign push_ready = ({1'b0, rem} + {1'b0, push_grp.cnt}) <= (CNT_W+1)'(2);
  assign push       = push_valid && push_ready;
  assign push_cnt   = push ? push_grp.cnt : '0;

  always_comb begin
    // Advance the head on a pop
    q0_nxt = pop ? q1_r : q0_r;
    q1_nxt = q1_r;
    // Append new items behind what remains
    if (rem == '0) begin
      if (push_cnt != '0) begin
        q0_nxt = push_grp.item0;
      end
      if (push_cnt == CNT_W'(2)) begin
        q1_nxt = push_grp.item1;
      end
    end else begin
      if (push_cnt != '0) begin
        q1_nxt = push_grp.item0;
      end
    end
    cnt_nxt = rem + push_cnt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q0_r <= q0_nxt;
    q1_r <= q1_nxt;
  end

endmodule

`default_nettype wire

@@ src/gray_pixel_quantize_bit_packer.sv @@
// Top level: input register, packing state and output queue.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one 8-bit gray pixel per item
//   plus in_last_pixel, which closes the image. Output channel
//   (out_valid/out_stall) carries packed bytes, earliest code in the MSBs;
//   out_last_byte marks the final byte of an image.
//   cfg_wr_en/cfg_wr_data set the code width (1..7, 0 acts as 1); write it
//   only while no items are in flight.
//   Throughput: one pixel per cycle while in_stall is low. A last pixel
//   that completes a byte and leaves a partial one yields two bytes, which
//   the output side drains at one byte per cycle while out_stall is low;
//   the two-entry output queue sets that figure. A completed byte passes
//   through the input register and then the output queue before it can
//   leave the block.
//   Reset empties the pipeline and the queue, clears the partial byte and
//   sets the code width to 4.
//   When the receiver stalls, the queue holds its bytes; once it cannot take
//   the next pixel's bytes, in_stall rises and the input register holds.
`default_nettype none

module gray_pixel_quantize_bit_packer
  import gpqbp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [PIX_W-1:0]  in_pixel,
  input  logic              in_last_pixel,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] out_packed_byte,
  output logic              out_last_byte,
  input  logic              cfg_wr_en,
  input  logic [BPP_W-1:0]  cfg_wr_data
);

  logic [BPP_W-1:0]  bpp_r;
  logic              valid_r;
  logic [PIX_W-1:0]  pixel_r;
  logic              last_r;
  logic [BYTE_W-1:0] partial_r;
  logic [FILL_W-1:0] fill_r;
  pack_res_t         res;
  logic              push_ready;
  logic              adv;
  out_item_t         out_item;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_r <= BPP_RESET;
    end else if (cfg_wr_en) begin
      bpp_r <= cfg_wr_data;
    end
  end

  // Hold the input register until its bytes fit in the queue
  assign adv      = valid_r && push_ready;
  assign in_stall = valid_r && !push_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      pixel_r <= in_pixel;
      last_r  <= in_last_pixel;
    end
  end

  gpqbp_quant_pack u_quant_pack (
    .pixel          (pixel_r),
    .last_pixel     (last_r),
    .bits_per_pixel (bpp_r),
    .partial        (partial_r),
    .fill           (fill_r),
    .res            (res)
  );

  // Advance the packing state when the item moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= '0;
      fill_r    <= '0;
    end else if (adv) begin
      partial_r <= res.partial_nxt;
      fill_r    <= res.fill_nxt;
    end
  end

  gpqbp_out_queue u_out_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (valid_r),
    .push_grp   (res.grp),
    .push_ready (push_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item)
  );

  assign out_packed_byte = out_item.data;
  assign out_last_byte   = out_item.last;

endmodule

`default_nettype wire

@@ tb/gray_pixel_quantize_bit_packer_test.sv @@
// Self-checking testbench for the gray pixel quantizer and bit packer.
`timescale 1ns / 1ps

module gray_pixel_quantize_bit_packer_test;
  import gpqbp_pkg::*;

  localparam int RAND_ITEMS   = 1350;
  localparam int PRESS_ITEMS  = 40;
  localparam int LONG_HOLD    = 120;
  localparam int DRAIN_CYCLES = 4;
  localparam int END_CYCLES   = 8;
  localparam int IDLE_LIMIT   = 2000;
  localparam int MAX_REPORTS  = 10;
  localparam int NUM_DIR      = 22;

  localparam logic [BPP_W-1:0] BPP_MAX = 3'd7;

  // One directed stimulus row; expected bytes are used only when typed is set
  typedef struct packed {
    logic             cfg_wr;
    logic [BPP_W-1:0] cfg_val;
    logic [PIX_W-1:0] pix;
    logic             last;
    logic             typed;
    logic [CNT_W-1:0] n;
    out_item_t        e0;
    out_item_t        e1;
  } dir_row_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  localparam out_item_t NO_BYTE = '0;

  // cfg_wr, width, pixel, last, typed, count, first byte, second byte
  localparam dir_row_t DIR_ROWS [NUM_DIR] = '{
    // reset width of 4: one nibble held, then a full byte, then a flush
    '{1'b0, BPP_ZERO,  8'hFF, 1'b0, 1'b1, 2'd0, NO_BYTE,        NO_BYTE},
    '{1'b0, BPP_ZERO,  8'h00, 1'b0, 1'b1, 2'd1, '{8'hF0, 1'b0}, NO_BYTE},
    '{1'b0, BPP_ZERO,  8'hA5, 1'b1, 1'b1, 2'd1, '{8'hA0, 1'b1}, NO_BYTE},
    // zero width acts as one bit; last pixel fills the byte exactly
    '{1'b1, BPP_ZERO,  8'h80, 1'b0, 1'b1, 2'd0, NO_BYTE,        NO_BYTE},
    '{1'b0, BPP_ZERO,  8'h00, 1'b0, 1'b1, 2'd0, NO_BYTE,        NO_BYTE},
    '{1'b0, BPP_ZERO,  8'hFF, 1'b0, 1'b1, 2'd0, NO_BYTE,        NO_BYTE},
    '{1'b0, BPP_ZERO,  8'h7F, 1'b0, 1'b1, 2'd0, NO_BYTE,        NO_BYTE},
    '{1'b0, BPP_ZERO,  8'h80, 1'b0, 1'b1, 2'd0, NO_BYTE,        NO_BYTE},
    '{1'b0, BPP_ZERO,  8'h00, 1'b0, 1'b1, 2'd0, NO_BYTE,        NO_BYTE},
    '{1'b0, BPP_ZERO,  8'hFF, 1'b0, 1'b1, 2'd0, NO_BYTE,        NO_BYTE},
    '{1'b0, BPP_ZERO,  8'h80, 1'b1, 1'b1, 2'd1, '{8'hAB, 1'b1}, NO_BYTE},
    // widest code: last pixel gives a full byte and a flushed one
    '{1'b1, BPP_MAX,   8'hFF, 1'b0, 1'b1, 2'd0, NO_BYTE,        NO_BYTE},
    '{1'b0, BPP_MAX,   8'hFF, 1'b1, 1'b1, 2'd2, '{8'hFF, 1'b0}, '{8'hFC, 1'b1}},
    // width changed while bits are held
    '{1'b1, 3'd3,      8'hE0, 1'b0, 1'b0, 2'd0, NO_BYTE,        NO_BYTE},
    '{1'b1, 3'd5,      8'h48, 1'b0, 1'b0, 2'd0, NO_BYTE,        NO_BYTE},
    '{1'b0, 3'd5,      8'h00, 1'b1, 1'b0, 2'd0, NO_BYTE,        NO_BYTE},
    '{1'b1, BPP_MIN,   8'h00, 1'b1, 1'b1, 2'd1, '{8'h00, 1'b1}, NO_BYTE},
    '{1'b1, 3'd2,      8'h40, 1'b0, 1'b0, 2'd0, NO_BYTE,        NO_BYTE},
    '{1'b0, 3'd2,      8'hC0, 1'b0, 1'b0, 2'd0, NO_BYTE,        NO_BYTE},
    '{1'b0, 3'd2,      8'h3F, 1'b0, 1'b0, 2'd0, NO_BYTE,        NO_BYTE},
    '{1'b0, 3'd2,      8'hFF, 1'b1, 1'b0, 2'd0, NO_BYTE,        NO_BYTE},
    // no last pixel: bits stay held into the next phase
    '{1'b1, 3'd6,      8'h12, 1'b0, 1'b0, 2'd0, NO_BYTE,        NO_BYTE}
  };

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [PIX_W-1:0]  in_pixel;
  logic              in_last_pixel;
  logic              out_valid;
  logic              out_stall;
  logic [BYTE_W-1:0] out_packed_byte;
  logic              out_last_byte;
  logic              cfg_wr_en;
  logic [BPP_W-1:0]  cfg_wr_data;

  // Packer state mirrored by the predictor
  logic [BPP_W-1:0]  pk_width;
  logic [BYTE_W-1:0] pk_partial;
  logic [FILL_W-1:0] pk_fill;
  out_item_t         pred_byte [2];

  out_item_t   expected_bytes [$];
  int          err_cnt;
  int          idle_cycles;
  int          burst_left;
  int          hold_left;
  int          stretch_left;
  bit          long_hold_req;
  stall_mode_t stall_mode;

  gray_pixel_quantize_bit_packer u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_pixel        (in_pixel),
    .in_last_pixel   (in_last_pixel),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_packed_byte (out_packed_byte),
    .out_last_byte   (out_last_byte),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Quantize one pixel, pack its code and return how many bytes it emits
  function automatic int pack_pixel(input logic [PIX_W-1:0] pix, input logic last);
    logic [BPP_W-1:0]   w;
    logic [PIX_W-1:0]   code;
    logic [TOTAL_W-1:0] total;
    logic [ACC_W-1:0]   acc;
    int                 n;
    w     = (pk_width == BPP_ZERO) ? BPP_MIN : pk_width;
    code  = pix >> (PIX_W - w);
    total = TOTAL_W'(pk_fill) + TOTAL_W'(w);
    acc   = {pk_partial, {BYTE_W{1'b0}}} | (ACC_W'(code) << (ACC_W - total));
    n     = 0;
    if (total >= BYTE_W) begin
      pred_byte[0] = '{data: acc[ACC_W-1:BYTE_W], last: 1'b0};
      n = 1;
      pk_partial = acc[BYTE_W-1:0];
      pk_fill    = FILL_W'(total - BYTE_W);
    end else begin
      pk_partial = acc[ACC_W-1:BYTE_W];
      pk_fill    = total[FILL_W-1:0];
    end
    // flush a partial byte, or flag the exact full one, and start over
    if (last) begin
      if (pk_fill != '0) begin
        pred_byte[n] = '{data: pk_partial, last: 1'b1};
        n++;
      end else if (n == 1) begin
        pred_byte[0].last = 1'b1;
      end
      pk_partial = '0;
      pk_fill    = '0;
    end
    return n;
  endfunction

  // Offer one item, hold it until accepted, then queue its bytes
  task automatic send_item(input dir_row_t r);
    int n;
    in_valid      <= 1'b1;
    in_pixel      <= r.pix;
    in_last_pixel <= r.last;
    do @(posedge clk); while (in_stall);
    n = pack_pixel(r.pix, r.last);
    if (r.typed) begin
      if (r.n > 0) expected_bytes.push_back(r.e0);
      if (r.n > 1) expected_bytes.push_back(r.e1);
    end else begin
      for (int k = 0; k < n; k++) expected_bytes.push_back(pred_byte[k]);
    end
  endtask

  task automatic idle_input(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Bursts of random length separated by random gaps
  task automatic pace_input();
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) idle_input(gap);
    end
    burst_left--;
  endtask

  // Hold the input until every queued byte is out and the pipeline is empty
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_width(input logic [BPP_W-1:0] val);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= val;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    pk_width = val;
  endtask

  function automatic logic [PIX_W-1:0] rand_pixel();
    if ($urandom_range(0, 7) == 0) return ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hFF;
    return PIX_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [BPP_W-1:0] rand_width();
    case ($urandom_range(0, 3))
      0: return BPP_MAX;
      1: return ($urandom_range(0, 1) == 0) ? BPP_ZERO : BPP_MIN;
      default: return BPP_W'($urandom_range(0, 7));
    endcase
  endfunction

  // Stimulus
  initial begin
    dir_row_t r;
    int       sent;
    int       img_len;
    bit       terminate;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_pixel      <= '0;
    in_last_pixel <= 1'b0;
    cfg_wr_en     <= 1'b0;
    cfg_wr_data   <= '0;
    pk_width   = BPP_RESET;
    pk_partial = '0;
    pk_fill    = '0;
    burst_left = 0;
    sent       = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows
    for (int row = 0; row < NUM_DIR; row++) begin
      r = DIR_ROWS[row];
      if (r.cfg_wr) begin
        wait_drained();
        write_width(r.cfg_val);
      end else begin
        pace_input();
      end
      send_item(r);
    end

    // back-to-back wide codes against a long receiver hold-off
    wait_drained();
    write_width(BPP_MAX);
    long_hold_req = 1'b1;
    for (int k = 0; k < PRESS_ITEMS; k++) begin
      r      = '0;
      r.pix  = rand_pixel();
      r.last = ($urandom_range(0, 15) == 0);
      send_item(r);
    end

    // random images, now and then at a new width
    while (sent < RAND_ITEMS) begin
      if ($urandom_range(0, 3) == 0) begin
        wait_drained();
        write_width(rand_width());
      end
      img_len   = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 64) : $urandom_range(1, 24);
      terminate = ($urandom_range(0, 9) != 0);
      for (int k = 0; k < img_len; k++) begin
        pace_input();
        r      = '0;
        r.pix  = rand_pixel();
        r.last = terminate && (k == img_len - 1);
        send_item(r);
        sent++;
      end
    end

    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);
    if (err_cnt == 0 && expected_bytes.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Receiver stall pattern, with one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall    <= 1'b0;
      hold_left    <= 0;
      stretch_left <= 0;
      stall_mode   <= STALL_NONE;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      out_stall <= 1'b1;
      hold_left <= LONG_HOLD - 1;
    end else begin
      if (stretch_left == 0) begin
        stall_mode   <= stall_mode_t'($urandom_range(0, 3));
        stretch_left <= $urandom_range(20, 80);
        out_stall    <= 1'b0;
      end else begin
        stretch_left <= stretch_left - 1;
        case (stall_mode)
          STALL_NONE:     out_stall <= 1'b0;
          STALL_LIGHT:    out_stall <= ($urandom_range(0, 9) < 3);
          STALL_HEAVY:    out_stall <= ($urandom_range(0, 9) < 7);
          STALL_PERIODIC: out_stall <= (stretch_left % 3 == 0);
          default:        out_stall <= 1'b0;
        endcase
      end
    end
  end

  // Compare each accepted byte with the oldest expectation
  always @(posedge clk) begin
    out_item_t exp_byte;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_bytes.size() == 0) begin
        if (err_cnt < MAX_REPORTS)
          $display("unexpected byte %02h last %0b", out_packed_byte, out_last_byte);
        err_cnt++;
      end else begin
        exp_byte = expected_bytes.pop_front();
        if (out_packed_byte !== exp_byte.data || out_last_byte !== exp_byte.last) begin
          if (err_cnt < MAX_REPORTS)
            $display("mismatch: byte exp %02h got %02h, last exp %0b got %0b",
                     exp_byte.data, out_packed_byte, exp_byte.last, out_last_byte);
          err_cnt++;
        end
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end else begin
      idle_cycles <= 0;
    end
  end

  initial begin
    err_cnt       = 0;
    long_hold_req = 1'b0;
  end

endmodule

@@ files.f @@
src/gpqbp_pkg.sv
src/gpqbp_quant_pack.sv
src/gpqbp_out_queue.sv
src/gray_pixel_quantize_bit_packer.sv
tb/gray_pixel_quantize_bit_packer_test.sv
